>>> rtl/core/spta_pkg.sv
package spta_pkg;

    localparam int MAX_TERMS_DEF = 16;

    localparam int COEFF_W  = 32;
    localparam int EXP_W    = 16;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;

    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MERGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUMP    = 3'd5;

    localparam logic [1:0] WS_MOVE = 2'd0;
    localparam logic [1:0] WS_SUM  = 2'd1;
    localparam logic [1:0] WS_NEW  = 2'd2;

    typedef struct packed {
        logic                in_ready;
        logic                latch_sum;
        logic                wr_en;
        logic [1:0]          wsel;
        logic                load_out;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    total;
        logic                last;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic in_mode;
        logic in_czero;
        logic exp_le;
        logic exp_eq;
        logic sum_zero;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/spta_in_if.sv
interface spta_in_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [spta_pkg::COEFF_W-1:0] coeff_in;
    logic        [spta_pkg::EXP_W-1:0]   exponent_in;

    modport source (output valid, mode, coeff_in, exponent_in, input ready);
    modport sink   (input valid, mode, coeff_in, exponent_in, output ready);
endinterface

>>> rtl/core/spta_out_if.sv
interface spta_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [spta_pkg::STATUS_W-1:0] status;
    logic        [spta_pkg::POS_W-1:0]    position;
    logic        [spta_pkg::POS_W-1:0]    term_total;
    logic        [spta_pkg::EXP_W-1:0]    out_exponent;
    logic signed [spta_pkg::COEFF_W-1:0]  out_coeff;
    logic                                 last;

    modport source (output valid, status, position, term_total, out_exponent, out_coeff,
                    last, input ready);
    modport sink   (input valid, status, position, term_total, out_exponent, out_coeff,
                    last, output ready);
endinterface

>>> rtl/core/spta_ctrl.sv
module spta_ctrl #(
    parameter int MAX_TERMS = spta_pkg::MAX_TERMS_DEF,
    parameter int AW        = $clog2(MAX_TERMS),
    parameter int CW        = $clog2(MAX_TERMS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spta_pkg::t_sts    i_sts,
    output spta_pkg::t_cmd    o_cmd,
    output logic [AW-1:0]     o_rd_addr,
    output logic [AW-1:0]     o_wr_addr
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_DN   = 3'd3;
    localparam logic [2:0] S_UP   = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;
    localparam logic [2:0] S_DUMP = 3'd7;

    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_pos, n_pos;
    logic                          r_match, n_match;
    logic [spta_pkg::STATUS_W-1:0] r_status, n_status;

    logic [CW-1:0] idx_p1, idx_m1, pos_p1, cnt_m1;

    assign idx_p1 = r_idx + ONE;
    assign idx_m1 = r_idx - ONE;
    assign pos_p1 = r_pos + ONE;
    assign cnt_m1 = r_cnt - ONE;

    // read address is n_idx, so the registered read data always matches r_idx
    assign o_rd_addr = n_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_match  <= n_match;
        r_status <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_match   = r_match;
        n_status  = r_status;
        o_wr_addr = r_pos[AW-1:0];

        o_cmd           = '0;
        o_cmd.wsel      = spta_pkg::WS_MOVE;
        o_cmd.status    = r_status;
        o_cmd.pos       = spta_pkg::POS_W'(r_pos);
        o_cmd.total     = spta_pkg::POS_W'(r_cnt);
        o_cmd.last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_fire) begin
                    n_idx = '0;
                    if (i_sts.in_mode) begin
                        if (r_cnt != '0) begin
                            n_state = S_DUMP;
                        end
                    end else if (i_sts.in_czero) begin
                        n_pos    = '0;
                        n_status = spta_pkg::ST_ZERO;
                        n_state  = S_RES;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_idx == r_cnt) begin
                    n_pos   = r_idx;
                    n_match = 1'b0;
                    n_state = S_DEC;
                end else if (i_sts.exp_le) begin
                    n_pos           = r_idx;
                    n_match         = i_sts.exp_eq;
                    o_cmd.latch_sum = 1'b1;
                    n_state         = S_DEC;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_DEC: begin
                if (r_match) begin
                    if (i_sts.sum_zero) begin
                        n_idx   = pos_p1;
                        n_state = S_DN;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wsel  = spta_pkg::WS_SUM;
                        n_status    = spta_pkg::ST_MERGE;
                        n_state     = S_RES;
                    end
                end else if (r_cnt == FULL) begin
                    n_status = spta_pkg::ST_FULL;
                    n_state  = S_RES;
                end else if (r_pos == r_cnt) begin
                    n_state = S_PUT;
                end else begin
                    n_idx   = cnt_m1;
                    n_state = S_UP;
                end
            end
            S_DN: begin
                if (r_idx == r_cnt) begin
                    n_cnt    = cnt_m1;
                    n_status = spta_pkg::ST_REMOVED;
                    n_state  = S_RES;
                end else begin
                    o_cmd.wr_en = 1'b1;
                    o_wr_addr   = idx_m1[AW-1:0];
                    n_idx       = idx_p1;
                end
            end
            S_UP: begin
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = idx_p1[AW-1:0];
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_idx = idx_m1;
                end
            end
            S_PUT: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wsel  = spta_pkg::WS_NEW;
                n_cnt       = r_cnt + ONE;
                n_status    = spta_pkg::ST_NEW;
                n_state     = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DUMP: begin
                o_cmd.status = spta_pkg::ST_DUMP;
                o_cmd.pos    = spta_pkg::POS_W'(r_idx);
                o_cmd.last   = (r_idx == cnt_m1);
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_idx          = idx_p1;
                    if (r_idx == cnt_m1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/spta_dp.sv
module spta_dp #(
    parameter int MAX_TERMS = spta_pkg::MAX_TERMS_DEF,
    parameter int AW        = $clog2(MAX_TERMS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    spta_in_if.sink         i_in,
    spta_out_if.source      o_out,
    input  spta_pkg::t_cmd  i_cmd,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic [AW-1:0]   i_wr_addr,
    output spta_pkg::t_sts  o_sts
);

    localparam int CWD = spta_pkg::COEFF_W;
    localparam int EWD = spta_pkg::EXP_W;

    logic        [EWD-1:0] mem_exp   [MAX_TERMS];
    logic signed [CWD-1:0] mem_coeff [MAX_TERMS];

    logic        [EWD-1:0] r_rd_exp;
    logic signed [CWD-1:0] r_rd_coeff;
    logic        [EWD-1:0] r_ex;
    logic signed [CWD-1:0] r_c;
    logic signed [CWD-1:0] r_sum;

    logic                          r_o_valid;
    logic [spta_pkg::STATUS_W-1:0] r_o_status;
    logic [spta_pkg::POS_W-1:0]    r_o_pos;
    logic [spta_pkg::POS_W-1:0]    r_o_total;
    logic [EWD-1:0]                r_o_exp;
    logic signed [CWD-1:0]         r_o_coeff;
    logic                          r_o_last;

    logic                  in_fire;
    logic signed [CWD:0]   sum_wide;
    logic signed [CWD-1:0] sum_sat;
    logic        [EWD-1:0] wr_exp;
    logic signed [CWD-1:0] wr_coeff;
    logic        [EWD-1:0] sel_exp;
    logic signed [CWD-1:0] sel_coeff;

    assign i_in.ready = i_cmd.in_ready;
    assign in_fire    = i_in.valid & i_cmd.in_ready;

    assign sum_wide = {r_rd_coeff[CWD-1], r_rd_coeff} + {r_c[CWD-1], r_c};

    always_comb begin
        if (sum_wide[CWD] != sum_wide[CWD-1]) begin
            sum_sat = sum_wide[CWD] ? {1'b1, {(CWD-1){1'b0}}} : {1'b0, {(CWD-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[CWD-1:0];
        end
    end

    always_comb begin
        case (i_cmd.wsel)
            spta_pkg::WS_SUM: begin
                wr_exp   = r_ex;
                wr_coeff = r_sum;
            end
            spta_pkg::WS_NEW: begin
                wr_exp   = r_ex;
                wr_coeff = r_c;
            end
            default: begin
                wr_exp   = r_rd_exp;
                wr_coeff = r_rd_coeff;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_exp[i_wr_addr]   <= wr_exp;
            mem_coeff[i_wr_addr] <= wr_coeff;
        end
        r_rd_exp   <= mem_exp[i_rd_addr];
        r_rd_coeff <= mem_coeff[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ex <= i_in.exponent_in;
            r_c  <= i_in.coeff_in;
        end
        if (i_cmd.latch_sum) begin
            r_sum <= sum_sat;
        end
    end

    always_comb begin
        sel_exp = (i_cmd.status == spta_pkg::ST_DUMP) ? r_rd_exp : r_ex;
        case (i_cmd.status) inside
            spta_pkg::ST_ZERO, spta_pkg::ST_REMOVED: sel_coeff = '0;
            spta_pkg::ST_NEW, spta_pkg::ST_FULL:     sel_coeff = r_c;
            spta_pkg::ST_MERGE:                      sel_coeff = r_sum;
            default:                                 sel_coeff = r_rd_coeff;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_o_status <= i_cmd.status;
            r_o_pos    <= i_cmd.pos;
            r_o_total  <= i_cmd.total;
            r_o_exp    <= sel_exp;
            r_o_coeff  <= sel_coeff;
            r_o_last   <= i_cmd.last;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.position     = r_o_pos;
    assign o_out.term_total   = r_o_total;
    assign o_out.out_exponent = r_o_exp;
    assign o_out.out_coeff    = r_o_coeff;
    assign o_out.last         = r_o_last;

    assign o_sts.in_fire  = in_fire;
    assign o_sts.in_mode  = i_in.mode;
    assign o_sts.in_czero = (i_in.coeff_in == '0);
    assign o_sts.exp_le   = (r_rd_exp <= r_ex);
    assign o_sts.exp_eq   = (r_rd_exp == r_ex);
    assign o_sts.sum_zero = (r_sum == '0);
    assign o_sts.out_free = ~r_o_valid | o_out.ready;

endmodule

>>> rtl/core/sorted_polynomial_term_accumulator_core.sv
// Channel | Dir | Fields
// i_in    | in  | mode, coeff_in (Q16.16), exponent_in
// o_out   | out | status, position, term_total, out_exponent, out_coeff, last
//
// Terms live in one memory kept sorted by falling exponent, one port each way.
// Insert: accept, linear search (one entry per cycle), decide, entry shift (one per
// cycle), write, result (held until the output is free). A match summing to zero
// removes its entry, shifting later ones down; a full table refuses a new term.
// A zero coefficient skips the search. Dump: one term per cycle while output is free.
// One item in flight at a time. Reset clears the count, state and output valid; the
// memory needs no clearing. A stalled output holds its register; the next item waits.
module sorted_polynomial_term_accumulator_core #(
    parameter int MAX_TERMS = spta_pkg::MAX_TERMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spta_in_if.sink     i_in,
    spta_out_if.source  o_out
);

    localparam int AW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);

    spta_pkg::t_cmd cmd;
    spta_pkg::t_sts sts;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    spta_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    spta_dp #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_sts     (sts)
    );

endmodule
